### rtl/iqr_pkg.sv
package iqr_pkg;

  localparam int unsigned MaxPoints  = 64;
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned IdxWidth   = $clog2(MaxPoints);
  localparam int unsigned CntWidth   = $clog2(MaxPoints + 1);
  localparam int unsigned FenceWidth = CoordWidth + 3;
  localparam int unsigned CfgWidth   = 7;
  localparam logic [CfgWidth-1:0] MinFilterReset = CfgWidth'(5);

  typedef logic [CoordWidth-1:0] coord_t;
  typedef logic [FenceWidth-1:0] fence_t;

  typedef enum logic [3:0] {
    StLoad,
    StCopy,
    StSortRd,
    StSortCmp,
    StQ1,
    StQ3,
    StFence,
    StEmitRd,
    StEmitChk,
    StEmitOut,
    StNone
  } state_e;

endpackage

### rtl/iqr_outlier_point_filter.sv
// Tukey-fence outlier filter. Points are taken one per cycle and stored in
// arrival order until a request with last_point_i set closes the set. A set
// smaller than min_filter_count is replayed unfiltered. Otherwise each of the
// three coordinates is copied to a scratch memory and insertion sorted by one
// shared compare unit, which does one compare or shift per step. The
// quartiles are then read and the fence pair is formed and written. The
// emit pass reads and checks each stored point in turn, a kept point takes a
// further step plus any wait for the output register, and a final step
// closes the set. The block is not ready from the closing request until its
// last result has been loaded into the output register.
// A set that ends with none kept gives one result with none_kept_o set.
module iqr_outlier_point_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [iqr_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [iqr_pkg::CoordWidth-1:0]  pos_x_i,
  input  logic [iqr_pkg::CoordWidth-1:0]  pos_y_i,
  input  logic [iqr_pkg::CoordWidth-1:0]  radius_i,
  input  logic                            last_point_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [iqr_pkg::CoordWidth-1:0]  out_x_o,
  output logic [iqr_pkg::CoordWidth-1:0]  out_y_o,
  output logic [iqr_pkg::CoordWidth-1:0]  out_r_o,
  output logic                            end_of_set_o,
  output logic                            none_kept_o,
  output logic                            overflowed_o
);

  localparam int unsigned IW = iqr_pkg::IdxWidth;
  localparam int unsigned CW = iqr_pkg::CntWidth;
  localparam int unsigned DW = iqr_pkg::CoordWidth;
  localparam int unsigned FW = iqr_pkg::FenceWidth;

  iqr_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [iqr_pkg::CfgWidth-1:0] min_q;
  logic          filt_q, filt_d;
  logic [1:0]    coord_q, coord_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [DW-1:0] v_q, v_d;
  logic [DW-1:0] q1_q, q1_d;
  logic [DW-1:0] q3_q, q3_d;
  logic          kept_q, kept_d;
  iqr_pkg::fence_t lo_q [3];
  iqr_pkg::fence_t hi_q [3];
  logic          fence_we;
  iqr_pkg::fence_t lo_new, hi_new;

  // Stores and scratch memory.
  logic [DW-1:0] mem_x [iqr_pkg::MaxPoints];
  logic [DW-1:0] mem_y [iqr_pkg::MaxPoints];
  logic [DW-1:0] mem_r [iqr_pkg::MaxPoints];
  logic [DW-1:0] scr   [iqr_pkg::MaxPoints];

  logic          st_we;
  logic [IW-1:0] st_wa;
  logic [IW-1:0] st_ra;
  logic [DW-1:0] rx_q, ry_q, rr_q;
  logic          sc_we;
  logic [IW-1:0] sc_wa, sc_ra;
  logic [DW-1:0] sc_wd, sc_q;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      mem_x[st_wa] <= pos_x_i;
      mem_y[st_wa] <= pos_y_i;
      mem_r[st_wa] <= radius_i;
    end
    rx_q <= mem_x[st_ra];
    ry_q <= mem_y[st_ra];
    rr_q <= mem_r[st_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) scr[sc_wa] <= sc_wd;
    sc_q <= scr[sc_ra];
  end

  logic [DW-1:0] rsel;
  always_comb begin
    case (coord_q)
      2'd0:    rsel = rx_q;
      2'd1:    rsel = ry_q;
      default: rsel = rr_q;
    endcase
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  logic [CW+1:0] n3;
  assign n3 = {2'b0, cnt_q} + {1'b0, cnt_q, 1'b0};

  // Shared fence arithmetic in Q.1.
  logic [FW-1:0] iqr3, lo2, hi2;
  always_comb begin
    iqr3   = FW'(q3_q - q1_q) * FW'(3);
    lo2    = {2'b0, q1_q, 1'b0};
    hi2    = {2'b0, q3_q, 1'b0};
    lo_new = (iqr3 > lo2) ? '0 : lo2 - iqr3;
    hi_new = hi2 + iqr3;
  end

  logic inside_ok;
  always_comb begin
    logic [FW-1:0] vx, vy, vr;
    vx = {2'b0, rx_q, 1'b0};
    vy = {2'b0, ry_q, 1'b0};
    vr = {2'b0, rr_q, 1'b0};
    inside_ok = !filt_q ||
      (vx >= lo_q[0] && vx <= hi_q[0] && vy >= lo_q[1] && vy <= hi_q[1] &&
       vr >= lo_q[2] && vr <= hi_q[2]);
  end

  logic [DW-1:0] ox_q, oy_q, or_q;
  logic          oend_q, onone_q, ovalid_q;
  logic          oload, onone_load, flush;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    filt_d   = filt_q;
    coord_d  = coord_q;
    i_d      = i_q;
    j_d      = j_q;
    v_d      = v_q;
    q1_d     = q1_q;
    q3_d     = q3_q;
    kept_d   = kept_q;
    st_we    = 1'b0;
    st_wa    = cnt_q[IW-1:0];
    st_ra    = i_q[IW-1:0];
    sc_we    = 1'b0;
    sc_wa    = j_q[IW-1:0];
    sc_wd    = v_q;
    sc_ra    = IW'(j_q - CW'(1));
    fence_we = 1'b0;
    oload    = 1'b0;
    onone_load = 1'b0;
    flush    = 1'b0;
    in_ready_o = (state_q == iqr_pkg::StLoad);
    unique case (state_q)
      iqr_pkg::StLoad: begin
        if (in_acc) begin
          if (cnt_q < CW'(iqr_pkg::MaxPoints)) begin
            st_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_point_i) begin
            filt_d  = ({1'b0, cnt_d} >= {1'b0, min_q}) && (cnt_d != '0);
            coord_d = 2'd0;
            i_d     = '0;
            kept_d  = 1'b0;
            state_d = (({1'b0, cnt_d} >= {1'b0, min_q}) && (cnt_d != '0))
                      ? iqr_pkg::StCopy : iqr_pkg::StEmitRd;
          end
        end
      end
      // Read store entry i; the value arrives next cycle.
      iqr_pkg::StCopy: begin
        st_ra   = i_q[IW-1:0];
        j_d     = i_q;
        state_d = iqr_pkg::StSortRd;
      end
      iqr_pkg::StSortRd: begin
        if (j_q == i_q) v_d = rsel;
        if (j_q == '0) begin
          state_d = iqr_pkg::StSortCmp;
        end else begin
          sc_ra   = IW'(j_q - CW'(1));
          state_d = iqr_pkg::StSortCmp;
        end
      end
      // One insertion step: shift a larger neighbor up or drop v in place.
      iqr_pkg::StSortCmp: begin
        if (j_q != '0 && sc_q > v_q) begin
          sc_we   = 1'b1;
          sc_wa   = j_q[IW-1:0];
          sc_wd   = sc_q;
          j_d     = j_q - CW'(1);
          state_d = iqr_pkg::StSortRd;
        end else begin
          sc_we = 1'b1;
          sc_wa = j_q[IW-1:0];
          sc_wd = v_q;
          if (i_q + CW'(1) == cnt_q) begin
            state_d = iqr_pkg::StQ1;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = iqr_pkg::StCopy;
          end
        end
      end
      iqr_pkg::StQ1: begin
        sc_ra   = IW'(cnt_q >> 2);
        state_d = iqr_pkg::StQ3;
      end
      iqr_pkg::StQ3: begin
        q1_d    = sc_q;
        sc_ra   = IW'(n3 >> 2);
        state_d = iqr_pkg::StFence;
      end
      // The pair is written in the next cycle, once q3 is registered.
      iqr_pkg::StFence: begin
        q3_d    = sc_q;
        state_d = iqr_pkg::StNone;
      end
      iqr_pkg::StNone: begin
        if (coord_q == 2'd3) begin
          // Close the set: the held point becomes the last result, or the
          // none-kept marker is sent when no point passed.
          if (!ovalid_q || out_ready_i) begin
            if (kept_q) flush = 1'b1;
            else onone_load = 1'b1;
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = iqr_pkg::StLoad;
          end
        end else begin
          fence_we = 1'b1;
          i_d      = '0;
          if (coord_q == 2'd2) begin
            coord_d = 2'd0;
            state_d = iqr_pkg::StEmitRd;
          end else begin
            coord_d = coord_q + 2'd1;
            state_d = iqr_pkg::StCopy;
          end
        end
      end
      iqr_pkg::StEmitRd: begin
        st_ra   = i_q[IW-1:0];
        state_d = iqr_pkg::StEmitChk;
      end
      iqr_pkg::StEmitChk: begin
        if (inside_ok) begin
          state_d = iqr_pkg::StEmitOut;
        end else if (i_q + CW'(1) == cnt_q) begin
          coord_d = 2'd3; state_d = iqr_pkg::StNone;
        end else begin
          i_d = i_q + CW'(1); state_d = iqr_pkg::StEmitRd;
        end
      end
      iqr_pkg::StEmitOut: begin
        if (!ovalid_q || out_ready_i) begin
          oload  = 1'b1;
          kept_d = 1'b1;
          if (i_q + CW'(1) == cnt_q) begin
            coord_d = 2'd3; state_d = iqr_pkg::StNone;
          end else begin
            i_d = i_q + CW'(1); state_d = iqr_pkg::StEmitRd;
          end
        end
      end
      default: state_d = iqr_pkg::StLoad;
    endcase
  end

  // The last kept point is only known once the scan ends, so each kept point
  // waits in a holding register until the next one is found or the set closes.
  logic          hold_q;
  logic [DW-1:0] hx_q, hy_q, hr_q;
  logic          hdrop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iqr_pkg::StLoad;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      min_q   <= iqr_pkg::MinFilterReset;
      filt_q  <= 1'b0;
      coord_q <= 2'd0;
      i_q     <= '0;
      j_q     <= '0;
      kept_q  <= 1'b0;
      ovalid_q <= 1'b0;
      hold_q  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= '0;
        hi_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      filt_q  <= filt_d;
      coord_q <= coord_d;
      i_q     <= i_d;
      j_q     <= j_d;
      kept_q  <= kept_d;
      if (cfg_we_i) min_q <= cfg_wdata_i;
      if (fence_we) begin
        lo_q[coord_q] <= lo_new;
        hi_q[coord_q] <= hi_new;
      end
      if (out_acc) ovalid_q <= 1'b0;
      // A held point is released when a later one is loaded or the set closes.
      if (hold_q && (oload || flush)) begin
        ovalid_q <= 1'b1;
        hold_q   <= 1'b0;
      end
      if (oload) hold_q <= 1'b1;
      if (onone_load) ovalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q  <= v_d;
    q1_q <= q1_d;
    q3_q <= q3_d;
    if (hold_q && (oload || flush)) begin
      ox_q    <= hx_q;
      oy_q    <= hy_q;
      or_q    <= hr_q;
      oend_q  <= flush;
      onone_q <= 1'b0;
      overflowed_o <= hdrop_q;
    end
    if (oload) begin
      hx_q    <= rx_q;
      hy_q    <= ry_q;
      hr_q    <= rr_q;
      hdrop_q <= drop_q;
    end
    if (onone_load) begin
      ox_q    <= '0;
      oy_q    <= '0;
      or_q    <= '0;
      oend_q  <= 1'b1;
      onone_q <= 1'b1;
      overflowed_o <= drop_q;
    end
  end

  // The held point becomes the last result when the set closes right after it.
  always_comb begin
    out_valid_o  = ovalid_q;
    out_x_o      = ox_q;
    out_y_o      = oy_q;
    out_r_o      = or_q;
    end_of_set_o = oend_q;
    none_kept_o  = onone_q;
  end

  a_ready_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == iqr_pkg::StLoad)
    else $error("ready outside load");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(iqr_pkg::MaxPoints))
    else $error("count above capacity");
  a_none_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_kept_o |-> end_of_set_o)
    else $error("none marker without end");

endmodule
